// ----- src/ffcc_pkg.sv -----
// Shared types, codes and widths for the fixed-function color combiner.
package ffcc_pkg;

  localparam int unsigned ARGB_W     = 32;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned MODE_W     = 26;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NUM_CH     = 4;

  // Channel lanes
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;
  localparam int unsigned CH_ALPHA = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_ZERO   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_ONE    = 2'd2;

  // Other color / alpha source
  localparam logic [1:0] OTHER_ITER  = 2'd0;
  localparam logic [1:0] OTHER_TEXEL = 2'd1;
  localparam logic [1:0] OTHER_CONST = 2'd2;

  // Local alpha source
  localparam logic [1:0] LALPHA_ITER  = 2'd0;
  localparam logic [1:0] LALPHA_CONST = 2'd1;
  localparam logic [1:0] LALPHA_Z     = 2'd2;
  localparam logic [1:0] LALPHA_W     = 2'd3;

  // Blend factor codes
  localparam logic [2:0] FACT_LOCAL_RGB   = 3'd1;
  localparam logic [2:0] FACT_OTHER_ALPHA = 3'd2;
  localparam logic [2:0] FACT_LOCAL_ALPHA = 3'd3;
  localparam logic [2:0] FACT_TEXEL_ALPHA = 3'd4;
  localparam logic [2:0] FACT_TEXEL_RGB   = 3'd5;

  // Color add codes
  localparam logic [1:0] ADD_LOCAL_RGB   = 2'd1;
  localparam logic [1:0] ADD_LOCAL_ALPHA = 2'd2;

  localparam logic [CH_W-1:0] BYTE_ONES = 8'hff;

  typedef struct packed {
    logic       a_invert;    // 25
    logic [1:0] a_add;       // 24:23
    logic       a_reverse;   // 22
    logic [2:0] a_factor;    // 21:19
    logic       a_sub;       // 18
    logic       a_zero;      // 17
    logic       c_invert;    // 16
    logic [1:0] c_add;       // 15:14
    logic       c_reverse;   // 13
    logic [2:0] c_factor;    // 12:10
    logic       c_sub;       // 9
    logic       c_zero;      // 8
    logic       override;    // 7
    logic [1:0] a_local;     // 6:5
    logic       c_local;     // 4
    logic [1:0] a_other;     // 3:2
    logic [1:0] c_other;     // 1:0
  } mode_t;

  typedef struct packed {
    logic [CH_W-1:0] other;
    logic [CH_W-1:0] loc;
    logic [CH_W-1:0] factor;
    logic [CH_W-1:0] add_val;
    logic            zero_other;
    logic            sub_local;
    logic            invert;
  } chan_op_t;

  typedef struct packed {
    logic [ARGB_W-1:0] iterated_argb;
    logic [ARGB_W-1:0] texel_argb;
    logic [CH_W-1:0]   z_alpha;
    logic [CH_W-1:0]   w_alpha;
  } pix_t;

  function automatic logic [CH_W-1:0] get_ch(input logic [ARGB_W-1:0] argb,
                                             input int unsigned ch);
    logic [CH_W-1:0] r;
    case (ch)
      CH_RED:   r = argb[23:16];
      CH_GREEN: r = argb[15:8];
      CH_BLUE:  r = argb[7:0];
      default:  r = argb[31:24];
    endcase
    return r;
  endfunction

endpackage

// ----- src/ffcc_in_if.sv -----
// Pixel request channel into the combiner.
interface ffcc_in_if;
  import ffcc_pkg::*;
  logic                valid;
  logic                ready;
  logic [ARGB_W-1:0]   iterated_argb;
  logic [ARGB_W-1:0]   texel_argb;
  logic [CH_W-1:0]     z_alpha;
  logic [CH_W-1:0]     w_alpha;

  modport source (output valid, iterated_argb, texel_argb, z_alpha, w_alpha,
                  input ready);
  modport sink   (input valid, iterated_argb, texel_argb, z_alpha, w_alpha,
                  output ready);
endinterface

// ----- src/ffcc_out_if.sv -----
// Combined pixel result channel.
interface ffcc_out_if;
  import ffcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   out_red;
  logic [CH_W-1:0]   out_green;
  logic [CH_W-1:0]   out_blue;
  logic [CH_W-1:0]   out_alpha;

  modport source (output valid, out_red, out_green, out_blue, out_alpha,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha,
                  output ready);
endinterface

// ----- src/ffcc_cfg_if.sv -----
// Configuration register write channel.
interface ffcc_cfg_if;
  import ffcc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/ffcc_cfg_regs.sv -----
// Combine mode and constant color registers.
module ffcc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  ffcc_cfg_if.sink                      cfg_wr,
  output ffcc_pkg::mode_t               mode,
  output logic [ffcc_pkg::ARGB_W-1:0]   const_zero,
  output logic [ffcc_pkg::ARGB_W-1:0]   const_one
);
  import ffcc_pkg::*;

  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ARGB_W-1:0] czero_r, czero_nxt;
  logic [ARGB_W-1:0] cone_r, cone_nxt;
  logic              wr_en;

  assign cfg_wr.ready = 1'b1;
  assign wr_en        = cfg_wr.valid;

  always_comb begin
    mode_nxt  = mode_r;
    czero_nxt = czero_r;
    cone_nxt  = cone_r;
    if (wr_en) begin
      unique case (cfg_wr.index)
        REG_COMBINE_MODE: mode_nxt  = cfg_wr.data[MODE_W-1:0];
        REG_CONST_ZERO:   czero_nxt = cfg_wr.data[ARGB_W-1:0];
        REG_CONST_ONE:    cone_nxt  = cfg_wr.data[ARGB_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      czero_r <= '0;
      cone_r  <= '0;
    end else begin
      mode_r  <= mode_nxt;
      czero_r <= czero_nxt;
      cone_r  <= cone_nxt;
    end
  end

  assign mode       = mode_t'(mode_r);
  assign const_zero = czero_r;
  assign const_one  = cone_r;
endmodule

// ----- src/ffcc_operand_sel.sv -----
// Source selection: other, local, blend factor and add term per channel.
module ffcc_operand_sel (
  input  ffcc_pkg::mode_t                             mode,
  input  logic [ffcc_pkg::ARGB_W-1:0]                 const_zero,
  input  logic [ffcc_pkg::ARGB_W-1:0]                 const_one,
  input  ffcc_pkg::pix_t                              pix,
  output ffcc_pkg::chan_op_t [ffcc_pkg::NUM_CH-1:0]   ops
);
  import ffcc_pkg::*;

  logic [ARGB_W-1:0] oc, oa_src, lc;
  logic [CH_W-1:0]   oa, la, ta;
  logic              use_const;

  function automatic logic [ARGB_W-1:0] pick_other(input logic [1:0] sel,
                                                   input logic [ARGB_W-1:0] it,
                                                   input logic [ARGB_W-1:0] tx,
                                                   input logic [ARGB_W-1:0] c1);
    logic [ARGB_W-1:0] r;
    unique case (sel)
      OTHER_ITER:  r = it;
      OTHER_TEXEL: r = tx;
      OTHER_CONST: r = c1;
      default:     r = '0;
    endcase
    return r;
  endfunction

  always_comb begin
    oc     = pick_other(mode.c_other, pix.iterated_argb, pix.texel_argb, const_one);
    oa_src = pick_other(mode.a_other, pix.iterated_argb, pix.texel_argb, const_one);
    oa     = get_ch(oa_src, CH_ALPHA);
    ta     = get_ch(pix.texel_argb, CH_ALPHA);

    // texel alpha MSB steers the local color when override is set
    use_const = mode.override ? ta[CH_W-1] : mode.c_local;
    lc        = use_const ? const_zero : pix.iterated_argb;

    unique case (mode.a_local)
      LALPHA_ITER:  la = get_ch(pix.iterated_argb, CH_ALPHA);
      LALPHA_CONST: la = get_ch(const_zero, CH_ALPHA);
      LALPHA_Z:     la = pix.z_alpha;
      LALPHA_W:     la = pix.w_alpha;
      default:      la = '0;
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_rgb
    logic [CH_W-1:0] lcc, fac;
    always_comb begin
      lcc = get_ch(lc, i);
      unique case (mode.c_factor)
        FACT_LOCAL_RGB:   fac = lcc;
        FACT_OTHER_ALPHA: fac = oa;
        FACT_LOCAL_ALPHA: fac = la;
        FACT_TEXEL_ALPHA: fac = ta;
        FACT_TEXEL_RGB:   fac = get_ch(pix.texel_argb, i);
        default:          fac = '0;
      endcase

      ops[i].other      = get_ch(oc, i);
      ops[i].loc        = lcc;
      ops[i].factor     = mode.c_reverse ? fac : (fac ^ BYTE_ONES);
      ops[i].zero_other = mode.c_zero;
      ops[i].sub_local  = mode.c_sub;
      ops[i].invert     = mode.c_invert;
      case (mode.c_add)
        ADD_LOCAL_RGB:   ops[i].add_val = lcc;
        ADD_LOCAL_ALPHA: ops[i].add_val = la;
        default:         ops[i].add_val = '0;
      endcase
    end
  end

  logic [CH_W-1:0] afac;
  always_comb begin
    case (mode.a_factor)
      FACT_LOCAL_RGB, FACT_LOCAL_ALPHA: afac = la;
      FACT_OTHER_ALPHA:                 afac = oa;
      FACT_TEXEL_ALPHA:                 afac = ta;
      default:                          afac = '0;
    endcase

    ops[CH_ALPHA].other      = oa;
    ops[CH_ALPHA].loc        = la;
    ops[CH_ALPHA].factor     = mode.a_reverse ? afac : (afac ^ BYTE_ONES);
    ops[CH_ALPHA].add_val    = (mode.a_add != 2'd0) ? la : '0;
    ops[CH_ALPHA].zero_other = mode.a_zero;
    ops[CH_ALPHA].sub_local  = mode.a_sub;
    ops[CH_ALPHA].invert     = mode.a_invert;
  end
endmodule

// ----- src/ffcc_channel.sv -----
// One channel of the combine: subtract, scale, shift, add, clamp, invert.
module ffcc_channel (
  input  ffcc_pkg::chan_op_t          op,
  output logic [ffcc_pkg::CH_W-1:0]   res
);
  import ffcc_pkg::*;

  logic signed [CH_W:0]     oth_s, loc_s, diff;
  logic        [CH_W:0]     fac_p1;
  logic signed [CH_W+1:0]   mult;
  logic signed [2*CH_W+2:0] prod;
  logic signed [CH_W+1:0]   scaled, sum;
  logic        [CH_W-1:0]   clamped;

  always_comb begin
    oth_s  = op.zero_other ? '0 : $signed({1'b0, op.other});
    loc_s  = op.sub_local  ? $signed({1'b0, op.loc}) : '0;
    diff   = oth_s - loc_s;
    fac_p1 = {1'b0, op.factor} + 9'd1;
    mult   = $signed({1'b0, fac_p1});
    prod   = diff * mult;
    // arithmetic shift right by 8 rounds toward minus infinity
    scaled = prod[2*CH_W+1:CH_W];
    sum    = scaled + $signed({2'b00, op.add_val});
    if (sum[CH_W+1])
      clamped = '0;
    else if (sum[CH_W])
      clamped = BYTE_ONES;
    else
      clamped = sum[CH_W-1:0];
    res = op.invert ? (clamped ^ BYTE_ONES) : clamped;
  end
endmodule

// ----- src/fixed_function_color_combiner.sv -----
// Top level of the fixed-function color combiner.
//
// Per pixel, combines iterated color, texel color and Z/W alpha bytes into
// one clamped ARGB result under control of the combine mode register.
// Channels (valid/ready, a request moves when both are high):
//   in_pix  : iterated_argb, texel_argb, z_alpha, w_alpha
//   out_pix : out_red, out_green, out_blue, out_alpha
//   cfg_wr  : index 0 combine_mode, 1 constant_color_zero,
//             2 constant_color_one; always ready, other indexes dropped.
// The path is one input register, the combine logic, one result
// register. Throughput is one pixel per clock while the receiver does not
// stall; the four channel multipliers work in parallel.
// When the receiver stalls, the result register holds and an empty input
// register still takes one request; once it is full, in_pix.ready drops.
// Reset (rst_n low, synchronous) clears both stage valids and the
// configuration registers to zero. Write configuration only while idle.
module fixed_function_color_combiner (
  input  logic        clk,
  input  logic        rst_n,
  ffcc_in_if.sink     in_pix,
  ffcc_out_if.source  out_pix,
  ffcc_cfg_if.sink    cfg_wr
);
  import ffcc_pkg::*;

  mode_t                  mode;
  logic [ARGB_W-1:0]      const_zero, const_one;
  chan_op_t [NUM_CH-1:0]  ops;
  logic [CH_W-1:0]        res [NUM_CH];

  logic                   s1_valid_r, s1_valid_nxt;
  pix_t                   s1_pix_r, s1_pix_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]        out_res_r [NUM_CH];
  logic [CH_W-1:0]        out_res_nxt [NUM_CH];
  logic                   out_free, in_take;

  ffcc_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .mode       (mode),
    .const_zero (const_zero),
    .const_one  (const_one)
  );

  ffcc_operand_sel u_sel (
    .mode       (mode),
    .const_zero (const_zero),
    .const_one  (const_one),
    .pix        (s1_pix_r),
    .ops        (ops)
  );

  for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
    ffcc_channel u_ch (
      .op  (ops[i]),
      .res (res[i])
    );
  end

  assign out_free     = !out_valid_r || out_pix.ready;
  assign in_pix.ready = !s1_valid_r || out_free;
  assign in_take      = in_pix.valid && in_pix.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_pix_nxt   = s1_pix_r;
    if (in_take) begin
      s1_valid_nxt             = 1'b1;
      s1_pix_nxt.iterated_argb = in_pix.iterated_argb;
      s1_pix_nxt.texel_argb    = in_pix.texel_argb;
      s1_pix_nxt.z_alpha       = in_pix.z_alpha;
      s1_pix_nxt.w_alpha       = in_pix.w_alpha;
    end else if (out_free) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_free) begin
      // advance the input stage into the result register
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r)
        out_res_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r  <= s1_pix_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.out_red   = out_res_r[CH_RED];
  assign out_pix.out_green = out_res_r[CH_GREEN];
  assign out_pix.out_blue  = out_res_r[CH_BLUE];
  assign out_pix.out_alpha = out_res_r[CH_ALPHA];
endmodule

// ----- src/ffcc_checker.sv -----
// Port-level checks for the color combiner, bound to the top level.
module ffcc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [4*ffcc_pkg::CH_W-1:0] out_data
);
  import ffcc_pkg::*;

  // Result stage empties on reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Input stalls only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled with free output");

  // Request followed by a free output gives a valid result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("result missing after request");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");
endmodule

bind fixed_function_color_combiner ffcc_checker u_ffcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_pix.valid),
  .in_ready  (in_pix.ready),
  .out_valid (out_pix.valid),
  .out_ready (out_pix.ready),
  .out_data  ({out_pix.out_red, out_pix.out_green, out_pix.out_blue, out_pix.out_alpha})
);

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the fixed-function color combiner.
module tb;
  import ffcc_pkg::*;

  localparam int LATENCY     = 2;
  localparam int CYCLE_LIMIT = 300000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
  } shade_t;

  logic clk;
  logic rst_n;

  ffcc_in_if  px_in ();
  ffcc_out_if px_out ();
  ffcc_cfg_if cfg_bus ();

  fixed_function_color_combiner DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (px_in),
    .out_pix (px_out),
    .cfg_wr  (cfg_bus)
  );

  mode_t                 mode_reg;
  logic [ARGB_W-1:0]     const_zero_reg;
  logic [ARGB_W-1:0]     const_one_reg;
  shade_t                expected_pixels [$];
  int                    mismatch_count = 0;
  int                    gap_pct = 0;
  int                    stall_pct = 0;
  int                    cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [ARGB_W-1:0] pick_other(input logic [1:0] sel, input pix_t p);
    case (sel)
      OTHER_ITER:  return p.iterated_argb;
      OTHER_TEXEL: return p.texel_argb;
      OTHER_CONST: return const_one_reg;
      default:     return '0;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] clamp_byte(input int v);
    if (v < 0) return '0;
    if (v > 255) return BYTE_ONES;
    return v[CH_W-1:0];
  endfunction

  function automatic shade_t combine_pixel(input pix_t p);
    logic [ARGB_W-1:0] oc, lc, tmp;
    logic [CH_W-1:0]   col [3];
    int                oa, la, ta, lcc, c, a, f, v;
    shade_t            s;
    oc  = pick_other(mode_reg.c_other, p);
    tmp = pick_other(mode_reg.a_other, p);
    oa  = tmp[31:24];
    ta  = p.texel_argb[31:24];
    // override lets the texel alpha MSB pick the local color
    if (mode_reg.override ? p.texel_argb[31] : mode_reg.c_local)
      lc = const_zero_reg;
    else
      lc = p.iterated_argb;
    case (mode_reg.a_local)
      LALPHA_ITER:  la = p.iterated_argb[31:24];
      LALPHA_CONST: la = const_zero_reg[31:24];
      LALPHA_Z:     la = p.z_alpha;
      default:      la = p.w_alpha;
    endcase
    for (int i = 0; i < 3; i++) begin
      lcc = lc[(16 - 8 * i) +: 8];
      if (mode_reg.c_zero) c = 0;
      else c = oc[(16 - 8 * i) +: 8];
      if (mode_reg.c_sub) c -= lcc;
      case (mode_reg.c_factor)
        FACT_LOCAL_RGB:   f = lcc;
        FACT_OTHER_ALPHA: f = oa;
        FACT_LOCAL_ALPHA: f = la;
        FACT_TEXEL_ALPHA: f = ta;
        FACT_TEXEL_RGB:   f = p.texel_argb[(16 - 8 * i) +: 8];
        default:          f = 0;
      endcase
      if (!mode_reg.c_reverse) f ^= 'hff;
      // arithmetic shift rounds toward minus infinity
      v = (c * (f + 1)) >>> 8;
      case (mode_reg.c_add)
        ADD_LOCAL_RGB:   v += lcc;
        ADD_LOCAL_ALPHA: v += la;
        default: ;
      endcase
      col[i] = clamp_byte(v) ^ (mode_reg.c_invert ? BYTE_ONES : '0);
    end
    if (mode_reg.a_zero) a = 0;
    else a = oa;
    if (mode_reg.a_sub) a -= la;
    // on the alpha path the local-rgb code also selects local alpha
    case (mode_reg.a_factor)
      FACT_LOCAL_RGB, FACT_LOCAL_ALPHA: f = la;
      FACT_OTHER_ALPHA:                 f = oa;
      FACT_TEXEL_ALPHA:                 f = ta;
      default:                          f = 0;
    endcase
    if (!mode_reg.a_reverse) f ^= 'hff;
    v = (a * (f + 1)) >>> 8;
    if (mode_reg.a_add != 2'd0) v += la;
    s.alpha = clamp_byte(v) ^ (mode_reg.a_invert ? BYTE_ONES : '0);
    s.red   = col[0];
    s.green = col[1];
    s.blue  = col[2];
    return s;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [ARGB_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic pix_t rand_pixel();
    pix_t              p;
    logic [ARGB_W-1:0] w;
    p.iterated_argb = pick_word();
    p.texel_argb    = pick_word();
    w = pick_word();
    p.z_alpha = w[CH_W-1:0];
    w = pick_word();
    p.w_alpha = w[CH_W-1:0];
    return p;
  endfunction

  task automatic send_pixel(input pix_t p);
    px_in.valid         <= 1'b1;
    px_in.iterated_argb <= p.iterated_argb;
    px_in.texel_argb    <= p.texel_argb;
    px_in.z_alpha       <= p.z_alpha;
    px_in.w_alpha       <= p.w_alpha;
    @(posedge clk);
    while (!px_in.ready) @(posedge clk);
    expected_pixels.push_back(combine_pixel(p));
    // hold valid high unless a gap follows
    if ($urandom_range(0, 99) < gap_pct) begin
      px_in.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_COMBINE_MODE: mode_reg = data[MODE_W-1:0];
      REG_CONST_ZERO:   const_zero_reg = data;
      REG_CONST_ONE:    const_one_reg = data;
      default: ;  // drop writes to unmapped indexes
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    px_in.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_state();
    gap_pct   = 20;
    stall_pct = 20;
    send_pixel('0);
    send_pixel('1);
    send_pixel(rand_pixel());
  endtask

  task automatic test_every_code();
    mode_t      m;
    logic [2:0] k;
    wait_idle();
    write_reg(REG_CONST_ZERO, $urandom());
    write_reg(REG_CONST_ONE, $urandom());
    for (int n = 0; n < 8; n++) begin
      k = n[2:0];
      m = '0;
      m.c_other   = k[1:0];
      m.a_other   = ~k[1:0];
      m.c_local   = k[0];
      m.a_local   = k[2:1];
      m.override  = k[1];
      m.c_zero    = (k == 3'd6);
      m.c_sub     = k[0] ^ k[2];
      m.c_factor  = k;
      m.c_reverse = k[1];
      m.c_add     = k[1:0];
      m.c_invert  = k[2] & k[0];
      m.a_zero    = (k == 3'd1);
      m.a_sub     = ~k[0];
      m.a_factor  = ~k;
      m.a_reverse = k[2];
      m.a_add     = k[2:1];
      m.a_invert  = k[1] & ~k[0];
      wait_idle();
      write_reg(REG_COMBINE_MODE, {{(CFG_DATA_W - MODE_W){1'b0}}, m});
      send_pixel('0);
      send_pixel('1);
      send_pixel(rand_pixel());
    end
  endtask

  task automatic test_random_modes();
    for (int ph = 0; ph < 14; ph++) begin
      wait_idle();
      gap_pct   = (ph % 3 == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = (ph % 4 == 1) ? 0 : $urandom_range(5, 40);
      if (ph == 0 || $urandom_range(0, 3) == 0)
        write_reg(REG_SPARE, $urandom());
      case (ph)
        0: begin
          write_reg(REG_COMBINE_MODE, '1);
          write_reg(REG_CONST_ZERO, '0);
          write_reg(REG_CONST_ONE, '1);
        end
        1: begin
          write_reg(REG_COMBINE_MODE, '0);
          write_reg(REG_CONST_ZERO, '1);
          write_reg(REG_CONST_ONE, '0);
        end
        default: begin
          write_reg(REG_COMBINE_MODE, $urandom());
          write_reg(REG_CONST_ZERO, pick_word());
          write_reg(REG_CONST_ONE, pick_word());
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        // drain the pipe once mid-stream
        if (ph == 5 && n == 50) wait_idle();
        send_pixel(rand_pixel());
      end
    end
  endtask

  task automatic test_full_rate();
    wait_idle();
    gap_pct   = 0;
    stall_pct = 0;
    write_reg(REG_COMBINE_MODE, $urandom());
    write_reg(REG_CONST_ZERO, $urandom());
    write_reg(REG_CONST_ONE, $urandom());
    repeat (170) send_pixel(rand_pixel());
  endtask

  // ---------------------------------------------------------------- result side

  initial begin
    px_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        px_out.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      px_out.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    shade_t want;
    if (rst_n && px_out.valid && px_out.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("result with no pixel request pending");
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (px_out.out_red !== want.red) begin
          $error("out_red: expected %0d, actual %0d", want.red, px_out.out_red);
          mismatch_count++;
        end
        if (px_out.out_green !== want.green) begin
          $error("out_green: expected %0d, actual %0d", want.green, px_out.out_green);
          mismatch_count++;
        end
        if (px_out.out_blue !== want.blue) begin
          $error("out_blue: expected %0d, actual %0d", want.blue, px_out.out_blue);
          mismatch_count++;
        end
        if (px_out.out_alpha !== want.alpha) begin
          $error("out_alpha: expected %0d, actual %0d", want.alpha, px_out.out_alpha);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_n               <= 1'b0;
    px_in.valid         <= 1'b0;
    px_in.iterated_argb <= '0;
    px_in.texel_argb    <= '0;
    px_in.z_alpha       <= '0;
    px_in.w_alpha       <= '0;
    cfg_bus.valid       <= 1'b0;
    cfg_bus.index       <= '0;
    cfg_bus.data        <= '0;
    mode_reg       = '0;
    const_zero_reg = '0;
    const_one_reg  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_every_code();
    test_random_modes();
    test_full_rate();

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
src/ffcc_pkg.sv
src/ffcc_in_if.sv
src/ffcc_out_if.sv
src/ffcc_cfg_if.sv
src/ffcc_cfg_regs.sv
src/ffcc_operand_sel.sv
src/ffcc_channel.sv
src/fixed_function_color_combiner.sv
src/ffcc_checker.sv
test/tb.sv
